FILE: rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int unsigned WideWidth = 64;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4,
        ACT_RND = 3'd5,
        ACT_NEG = 3'd6,
        ACT_INV = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SIGN,
        ST_RDIV,
        ST_RFIX,
        ST_GCD,
        ST_QDIV,
        ST_DDIV,
        ST_DONE
    } t_state;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sign;
        logic div_start;
        logic div_step;
        logic rnd_fix;
        logic gcd_swap;
        logic take_num;
        logic take_den;
        logic div_den_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early;
        logic div_last;
        logic gcd_zero;
        logic num_zero;
    } t_status;
endpackage
`default_nettype wire

FILE: rtl/core/rau_ctrl.sv
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic [2:0] i_action,
    input  wire t_status i_stat,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_done
);
    t_state r_state, n_state;
    t_action r_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_act   <= ACT_ADD;
        end else begin
            r_state <= n_state;
            if (i_start && r_state == ST_IDLE) begin
                r_act <= t_action'(i_action);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start) n_state = ST_MUL1;
            ST_MUL1: n_state = i_stat.early ? ST_DONE : ST_MUL2;
            ST_MUL2: n_state = ST_SIGN;
            ST_SIGN: begin
                if (r_act == ACT_CMP) n_state = ST_DONE;
                else if (r_act == ACT_RND) n_state = ST_RDIV;
                else if (i_stat.num_zero) n_state = ST_DONE;
                else n_state = ST_GCD;
            end
            ST_RDIV: if (i_stat.div_last) n_state = ST_RFIX;
            ST_RFIX: n_state = ST_DONE;
            ST_GCD: if (i_stat.gcd_zero) n_state = ST_QDIV;
            ST_QDIV: if (i_stat.div_last) n_state = ST_DDIV;
            ST_DDIV: if (i_stat.div_last) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        case (r_state)
            ST_IDLE: o_cmd.load = i_start;
            ST_MUL1: o_cmd.mul1 = 1'b1;
            ST_MUL2: o_cmd.mul2 = 1'b1;
            ST_SIGN: begin
                o_cmd.sign = 1'b1;
                o_cmd.div_start = (r_act == ACT_RND) ||
                                  (r_act != ACT_CMP && !i_stat.num_zero);
            end
            ST_RDIV: o_cmd.div_step = 1'b1;
            ST_RFIX: o_cmd.rnd_fix = 1'b1;
            ST_GCD: begin
                o_cmd.gcd_swap = 1'b1;
                o_cmd.div_step = !i_stat.gcd_zero;
                o_cmd.div_start = i_stat.gcd_zero;
            end
            ST_QDIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.take_num = i_stat.div_last;
                o_cmd.div_start = i_stat.div_last;
                o_cmd.div_den_sel = i_stat.div_last;
            end
            ST_DDIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.take_den = i_stat.div_last;
            end
            default: o_cmd = '0;
        endcase
    end

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("done not followed by idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");
    a_start_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start ignored");
endmodule
`default_nettype wire

FILE: rtl/core/rau_dp.sv
`default_nettype none
module rau_dp
    import rau_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_a_num,
    input  wire logic [30:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [30:0] i_b_den,
    input  wire t_cmd        i_cmd,
    output t_status          o_stat,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic             o_is_less,
    output logic             o_is_equal,
    output logic             o_is_greater,
    output logic             o_zero_divide,
    output logic             o_overflow
);
    localparam logic [63:0] Half = 64'd1 << (VALUE_WIDTH - 1);

    logic [2:0]  r_act;
    logic signed [32:0] r_an, r_ad, r_bn, r_bd;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [64:0] r_n, r_d;
    logic        r_neg;
    logic [63:0] r_x, r_y, r_dvd, r_dvs, r_quo, r_rem, r_g, r_nm;
    logic [6:0]  r_cnt;
    logic        w_early;
    logic signed [32:0] m_a0, m_b0, m_a1, m_b1;
    logic signed [64:0] n_n, n_d;
    logic [64:0] rem_sh, rem_sub;
    logic [63:0] n_nm, n_dm;

    always_comb begin
        m_a0 = r_an; m_b0 = r_bd; m_a1 = r_bn; m_b1 = r_ad;
        if (i_cmd.mul2) begin
            m_a0 = r_ad; m_b0 = r_bd; m_a1 = r_ad; m_b1 = r_bn;
            if (t_action'(r_act) == ACT_MUL) m_a1 = r_an;
        end
    end

    always_comb begin
        n_n = '0; n_d = 65'sd1;
        case (t_action'(r_act))
            ACT_ADD: begin n_n = r_p0 + r_p1; n_d = r_p2; end
            ACT_SUB: begin n_n = r_p0 - r_p1; n_d = r_p2; end
            ACT_MUL: begin n_n = r_p3; n_d = r_p2; end
            ACT_DIV: begin n_n = r_p0; n_d = r_p3; end
            ACT_RND: begin n_n = 2 * r_an + r_ad; n_d = 2 * r_ad; end
            ACT_NEG: begin n_n = -r_an; n_d = r_ad; end
            ACT_INV: begin n_n = r_ad; n_d = r_an; end
            default: begin n_n = '0; n_d = 65'sd1; end
        endcase
        n_nm = n_n[64] ? 64'(-n_n) : 64'(n_n);
        n_dm = n_d[64] ? 64'(-n_d) : 64'(n_d);
    end

    assign rem_sh  = {r_rem, r_dvd[63]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_an <= 33'(signed'(i_a_num));
            r_ad <= {2'b0, i_a_den};
            r_bn <= 33'(signed'(i_b_num));
            r_bd <= {2'b0, i_b_den};
            o_is_less <= 1'b0; o_is_equal <= 1'b0; o_is_greater <= 1'b0;
            o_zero_divide <= 1'b0; o_overflow <= 1'b0;
            o_res_num <= '0; o_res_den <= 31'd1;
        end
        if (i_cmd.mul1) begin
            r_p0 <= 64'(m_a0 * m_b0);
            r_p1 <= 64'(m_a1 * m_b1);
            o_zero_divide <= w_early;
        end
        if (i_cmd.mul2) begin
            r_p2 <= 64'(m_a0 * m_b0);
            r_p3 <= 64'(m_a1 * m_b1);
        end
        if (i_cmd.sign) begin
            r_n <= n_n; r_d <= n_d;
            r_neg <= n_n[64] ^ n_d[64];
            r_x <= n_nm; r_y <= n_dm; r_nm <= n_nm;
            if (t_action'(r_act) == ACT_CMP) begin
                o_is_less <= r_p0 < r_p3;
                o_is_equal <= r_p0 == r_p3;
                o_is_greater <= r_p0 > r_p3;
            end
            if (t_action'(r_act) == ACT_RND) begin
                r_dvd <= n_nm; r_dvs <= n_dm;
            end else begin
                r_dvd <= n_nm; r_dvs <= n_dm;
            end
            r_rem <= '0; r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (!rem_sub[64]) begin
                r_rem <= rem_sub[63:0];
                r_dvd <= {r_dvd[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_dvd <= {r_dvd[62:0], 1'b0};
            end
            r_cnt <= r_cnt + 7'd1;
        end
        // The last divider step yields the remainder: advance Euclid with it.
        if (i_cmd.gcd_swap) begin
            if (r_cnt == 7'd63 || r_y == 64'd0) begin
                if (r_y == 64'd0) r_g <= r_x;
                else begin
                    r_x <= r_y; r_y <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
                    r_dvd <= r_y; r_dvs <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
                    r_rem <= '0; r_cnt <= '0;
                end
            end
        end
        if (i_cmd.div_start && !i_cmd.sign) begin
            r_rem <= '0; r_cnt <= '0;
            r_dvd <= i_cmd.div_den_sel ? r_d[64] ? 64'(-r_d) : 64'(r_d) : r_nm;
            r_dvs <= i_cmd.gcd_swap ? r_x : r_g;
        end
        if (i_cmd.take_num) r_quo <= {r_dvd[62:0], ~rem_sub[64]};
        if (i_cmd.take_den) begin
            logic [63:0] qd;
            qd = {r_dvd[62:0], ~rem_sub[64]};
            if (qd > Half - 64'd1 || (r_neg ? r_quo > Half : r_quo > Half - 64'd1)) begin
                o_overflow <= 1'b1;
            end else begin
                o_res_num <= 32'(r_neg ? -r_quo : r_quo);
                o_res_den <= 31'(qd);
            end
        end
        if (i_cmd.rnd_fix) begin
            logic signed [64:0] f;
            f = r_n[64] ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
            if (r_n[64] && r_rem != 64'd0) f = f - 65'sd1;
            if (f > $signed({1'b0, Half - 64'd1}) || f < -$signed({1'b0, Half}))
                o_overflow <= 1'b1;
            else
                o_res_num <= 32'(f);
        end
    end

    // Invalid denominators, zero divisors and zero inversions short out.
    always_comb begin
        w_early = (r_ad == 33'sd0) || (r_act <= 3'd4 && r_bd == 33'sd0) ||
                  (t_action'(r_act) == ACT_DIV && r_bn == 33'sd0) ||
                  (t_action'(r_act) == ACT_INV && r_an == 33'sd0);
    end

    assign o_stat.early = w_early;
    assign o_stat.div_last = (r_cnt == 7'd63);
    assign o_stat.gcd_zero = (r_y == 64'd0);
    assign o_stat.num_zero = (n_nm == 64'd0);
endmodule
`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
`default_nettype none
// Channel  | Ports                                     | Timing
// command  | start, busy, i_action, i_a_*, i_b_*       | beat when start && !busy
// result   | o_valid, o_res_*, o_is_*, o_zero_divide,  | beat is the single o_valid cycle
//          | o_overflow                                |
// Zero divides and bad denominators end after the first multiply, compare and
// zero results after the sign step, round after one division and its fix-up,
// and fraction results after Euclid and the two final quotient divisions: a
// 64-step restoring divider is shared by every Euclid remainder and the two final
// quotient divisions. A new beat is taken the cycle after o_valid.
// Reset clears the controller only. The receiver cannot stall.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_a_num,
    input  wire logic [30:0] i_a_den,
    input  wire logic [31:0] i_b_num,
    input  wire logic [30:0] i_b_den,
    output logic             o_valid,
    output logic [31:0]      o_res_num,
    output logic [30:0]      o_res_den,
    output logic             o_is_less,
    output logic             o_is_equal,
    output logic             o_is_greater,
    output logic             o_zero_divide,
    output logic             o_overflow
);
    t_cmd    w_cmd;
    t_status w_stat;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_action(i_action),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid)
    );

    rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk(i_clk), .i_action(i_action), .i_a_num(i_a_num), .i_a_den(i_a_den),
        .i_b_num(i_b_num), .i_b_den(i_b_den), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_res_num(o_res_num), .o_res_den(o_res_den), .o_is_less(o_is_less),
        .o_is_equal(o_is_equal), .o_is_greater(o_is_greater),
        .o_zero_divide(o_zero_divide), .o_overflow(o_overflow)
    );
endmodule
`default_nettype wire

FILE: verif/tb_rational_arithmetic_unit.sv
`default_nettype none
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    // Operand beat and result beat, at the port widths.
    typedef struct {
        t_action     action;
        logic [31:0] a_num;
        logic [30:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
        bit          drain;   // hold this beat until every result is back
        int          gap;     // idle cycles after this beat
    } t_operands;

    typedef struct {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        is_less;
        logic        is_equal;
        logic        is_greater;
        logic        zero_divide;
        logic        overflow;
    } t_fraction_result;

    localparam int IDLE_LIMIT = 50000;
    localparam int RANDOM_ITEMS = 1100;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [31:0] i_a_num;
    logic [30:0] i_a_den;
    logic [31:0] i_b_num;
    logic [30:0] i_b_den;
    logic        o_valid;
    logic [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic        o_is_less;
    logic        o_is_equal;
    logic        o_is_greater;
    logic        o_zero_divide;
    logic        o_overflow;

    t_operands        pending_operands[$];
    t_fraction_result expected_results[$];
    int               beats_accepted = 0;
    int               beats_issued = 0;
    int               idle_cycles = 0;
    int               error_count = 0;

    rational_arithmetic_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_valid      (o_valid),
        .o_res_num    (o_res_num),
        .o_res_den    (o_res_den),
        .o_is_less    (o_is_less),
        .o_is_equal   (o_is_equal),
        .o_is_greater (o_is_greater),
        .o_zero_divide(o_zero_divide),
        .o_overflow   (o_overflow)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Euclid on magnitudes.
    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Reduce the exact fraction n/d and apply the width check.
    function automatic void reduce_into(longint n, longint d, inout t_fraction_result r);
        bit              neg;
        longint unsigned nm, dm, g, half;
        half = 64'd1 << 31;
        neg  = (n < 0) != (d < 0);
        nm   = (n < 0) ? -n : n;
        dm   = (d < 0) ? -d : d;
        if (nm == 0)
            return;
        g  = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm > half - 1 || (neg ? nm > half : nm > half - 1)) begin
            r.overflow = 1'b1;
            return;
        end
        r.res_num = neg ? 32'(-nm) : 32'(nm);
        r.res_den = 31'(dm);
    endfunction

    function automatic t_fraction_result predict_fraction(t_operands op);
        t_fraction_result r;
        longint an, ad, bn, bd, n, d, lhs, rhs, t, q, f;
        r  = '{res_num: 32'd0, res_den: 31'd1, default: 1'b0};
        an = longint'(signed'(op.a_num));
        ad = longint'({1'b0, op.a_den});
        bn = longint'(signed'(op.b_num));
        bd = longint'({1'b0, op.b_den});
        // Zero denominator on a used operand acts like a zero divide.
        if (ad == 0 || (op.action <= ACT_CMP && bd == 0)) begin
            r.zero_divide = 1'b1;
            return r;
        end
        case (op.action)
            ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            ACT_MUL: begin n = an * bn; d = ad * bd; end
            ACT_DIV: begin
                if (bn == 0) begin
                    r.zero_divide = 1'b1;
                    return r;
                end
                n = an * bd;
                d = ad * bn;
            end
            ACT_CMP: begin
                lhs = an * bd;
                rhs = ad * bn;
                r.is_less    = lhs < rhs;
                r.is_equal   = lhs == rhs;
                r.is_greater = lhs > rhs;
                return r;
            end
            ACT_RND: begin
                // floor of a + 1/2, exact
                t = 2 * an + ad;
                q = 2 * ad;
                f = t / q;
                if (t % q != 0 && t < 0)
                    f = f - 1;
                n = f;
                d = 1;
            end
            ACT_NEG: begin n = -an; d = ad; end
            default: begin
                if (an == 0) begin
                    r.zero_divide = 1'b1;
                    return r;
                end
                n = ad;
                d = an;
            end
        endcase
        reduce_into(n, d, r);
        return r;
    endfunction

    function automatic logic [31:0] draw_num();
        case ($urandom_range(0, 4))
            0: return 32'($signed($urandom_range(0, 40)) - 20);
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] draw_den();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 4) == 0) ? 31'd0 : 31'h7FFF_FFFF;
            1, 2: return 31'($urandom_range(1, 12));
            3, 4: return 31'($urandom_range(1, 1000));
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic int draw_gap();
        // Mix back-to-back bursts with random idling.
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic queue_operands(t_action act, logic [31:0] an, logic [30:0] ad,
                                  logic [31:0] bn, logic [30:0] bd, bit drain);
        pending_operands.push_back('{act, an, ad, bn, bd, drain, draw_gap()});
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Driver: change inputs at the falling edge with nonblocking writes.
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && beats_accepted != beats_issued) begin
            // hold the beat until the block takes it
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (pending_operands.size() > 0 &&
                     (!pending_operands[0].drain || expected_results.size() == 0)) begin
            i_action <= pending_operands[0].action;
            i_a_num  <= pending_operands[0].a_num;
            i_a_den  <= pending_operands[0].a_den;
            i_b_num  <= pending_operands[0].b_num;
            i_b_den  <= pending_operands[0].b_den;
            gap_left  = pending_operands[0].gap;
            void'(pending_operands.pop_front());
            start <= 1'b1;
            beats_issued++;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: sample at the rising edge, check results, record accepted beats.
    always @(posedge i_clk) begin
        t_operands        seen;
        t_fraction_result want;
        if (i_rst_n) begin
            if (o_valid || (start && !busy)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h/%h", $time,
                             o_res_num, o_res_den);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("res_num", want.res_num, o_res_num);
                    check_field("res_den", 32'(want.res_den), 32'(o_res_den));
                    check_field("is_less", 32'(want.is_less), 32'(o_is_less));
                    check_field("is_equal", 32'(want.is_equal), 32'(o_is_equal));
                    check_field("is_greater", 32'(want.is_greater), 32'(o_is_greater));
                    check_field("zero_divide", 32'(want.zero_divide), 32'(o_zero_divide));
                    check_field("overflow", 32'(want.overflow), 32'(o_overflow));
                end
            end
            if (start && !busy) begin
                seen.action = t_action'(i_action);
                seen.a_num  = i_a_num;
                seen.a_den  = i_a_den;
                seen.b_num  = i_b_num;
                seen.b_den  = i_b_den;
                expected_results.push_back(predict_fraction(seen));
                beats_accepted++;
            end
        end
    end

    // Watchdog: drop the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** rational_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        t_action act;
        start    = 1'b0;
        i_rst_n  = 1'b0;
        i_action = ACT_ADD;
        i_a_num  = '0;
        i_a_den  = 31'd1;
        i_b_num  = '0;
        i_b_den  = 31'd1;

        // Directed: extremes, every action, zero divides, overflow, rounding ties.
        queue_operands(ACT_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 1'b0);
        queue_operands(ACT_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1, 1'b0);
        queue_operands(ACT_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1, 1'b0);
        queue_operands(ACT_SUB, 32'd3, 31'd6, 32'd1, 31'd2, 1'b0);
        queue_operands(ACT_MUL, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
        queue_operands(ACT_MUL, -32'sd6, 31'd4, 32'd2, 31'd9, 1'b0);
        queue_operands(ACT_DIV, 32'd1, 31'd2, 32'd0, 31'd5, 1'b0);
        queue_operands(ACT_DIV, 32'd3, 31'd4, -32'sd9, 31'd8, 1'b0);
        queue_operands(ACT_DIV, 32'd5, 31'd0, 32'd1, 31'd1, 1'b0);
        queue_operands(ACT_ADD, 32'd5, 31'd1, 32'd1, 31'd0, 1'b0);
        queue_operands(ACT_CMP, 32'd1, 31'd2, 32'd2, 31'd4, 1'b0);
        queue_operands(ACT_CMP, -32'sd1, 31'd3, 32'd1, 31'd3, 1'b0);
        queue_operands(ACT_CMP, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1, 1'b0);
        queue_operands(ACT_CMP, 32'd1, 31'd1, 32'd1, 31'd0, 1'b0);
        queue_operands(ACT_RND, 32'd1, 31'd2, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_RND, -32'sd1, 31'd2, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_RND, -32'sd7, 31'd3, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_RND, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_NEG, 32'd0, 31'd9, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_INV, 32'd0, 31'd3, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_INV, -32'sd4, 31'd6, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_INV, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 1'b0);
        queue_operands(ACT_NEG, 32'd5, 31'd0, 32'd0, 31'd0, 1'b1);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            act = t_action'($urandom_range(0, 7));
            queue_operands(act, draw_num(), draw_den(), draw_num(), draw_den(),
                           (k % 200) == 199);
        end

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_operands.size() == 0 && beats_accepted == beats_issued);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("** rational_arithmetic_unit: PASSED **");
        end else begin
            $display("** rational_arithmetic_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
